// File: rtl/vfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vfs_pkg;

    localparam int COORD_W = 32;
    localparam int CANVAS_W = 16;
    localparam int SCALE_W = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int SCALE_FRAC_BITS_DEF = 16;

    localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RST = 16'd1024;
    localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RST = 16'd768;

    // register index, taken from paddr[2]
    localparam logic REG_CANVAS_WIDTH = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    // request mode
    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_TRANSFORM = 1'b1;

    typedef struct packed {
        logic measure;
        logic capture;
        logic div_start_x;
        logic div_start_y;
        logic take_rx;
        logic take_ry;
        logic mul_sx;
        logic mul_sy;
        logic off_y;
        logic map_x;
        logic map_y;
        logic out_load;
    } vfs_cmd_t;

    typedef struct packed {
        logic scale_ready;
        logic div_done;
    } vfs_status_t;

endpackage

`default_nettype wire

// File: rtl/vfs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vfs_in_if;
    import vfs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic                       skip;

    modport source (output valid, mode, x, y, skip, input ready);
    modport sink (input valid, mode, x, y, skip, output ready);
endinterface

interface vfs_out_if;
    import vfs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic                       below_min;
    logic                       degenerate;

    modport source (output valid, out_x, out_y, below_min, degenerate, input ready);
    modport sink (input valid, out_x, out_y, below_min, degenerate, output ready);
endinterface

`default_nettype wire

// File: rtl/vfs_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle; quotient saturates to 32 bits.
module vfs_div #(
    parameter int DW = 40
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [DW-1:0]                  dividend,
    input  wire logic [vfs_pkg::SCALE_W-1:0]    divisor,
    output logic                                done,
    output logic [vfs_pkg::SCALE_W-1:0]         quotient
);
    import vfs_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic               done_reg;
    logic [DW-1:0]      quo_reg;
    logic [SCALE_W-1:0] rem_reg;
    logic [SCALE_W-1:0] dvs_reg;
    logic [SCALE_W:0]   shifted;
    logic               fits;
    logic [DW-1:0]      quo_hi;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign fits = shifted >= {1'b0, dvs_reg};
    assign cnt_next = cnt_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(DW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? SCALE_W'(shifted - {1'b0, dvs_reg}) : SCALE_W'(shifted);
        end
    end

    assign quo_hi = quo_reg >> SCALE_W;
    assign done = done_reg;
    assign quotient = (quo_hi != '0) ? '1 : SCALE_W'(quo_reg);

endmodule

`default_nettype wire

// File: rtl/vfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vfs_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_mode,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output vfs_pkg::vfs_cmd_t           cmd,
    input  wire vfs_pkg::vfs_status_t   status
);
    import vfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_X_GO,
        S_DIV_X,
        S_DIV_Y_GO,
        S_DIV_Y,
        S_MUL_SX,
        S_MUL_SY,
        S_OFF_Y,
        S_MAP_X,
        S_MAP_Y,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == MODE_MEASURE)
                    begin
                        cmd.measure = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next = status.scale_ready ? S_MAP_X : S_DIV_X_GO;
                    end
                end
            end
            S_DIV_X_GO:
            begin
                cmd.div_start_x = 1'b1;
                state_next = S_DIV_X;
            end
            S_DIV_X:
            begin
                if (status.div_done)
                begin
                    cmd.take_rx = 1'b1;
                    state_next = S_DIV_Y_GO;
                end
            end
            S_DIV_Y_GO:
            begin
                cmd.div_start_y = 1'b1;
                state_next = S_DIV_Y;
            end
            S_DIV_Y:
            begin
                if (status.div_done)
                begin
                    cmd.take_ry = 1'b1;
                    state_next = S_MUL_SX;
                end
            end
            S_MUL_SX:
            begin
                cmd.mul_sx = 1'b1;
                state_next = S_MUL_SY;
            end
            S_MUL_SY:
            begin
                cmd.mul_sy = 1'b1;
                state_next = S_OFF_Y;
            end
            S_OFF_Y:
            begin
                cmd.off_y = 1'b1;
                state_next = S_MAP_X;
            end
            S_MAP_X:
            begin
                cmd.map_x = 1'b1;
                state_next = S_MAP_Y;
            end
            S_MAP_Y:
            begin
                cmd.map_y = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/vfs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module vfs_dp #(
    parameter int COORD_FRAC_BITS = vfs_pkg::COORD_FRAC_BITS_DEF,
    parameter int SCALE_FRAC_BITS = vfs_pkg::SCALE_FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire vfs_pkg::vfs_cmd_t                  cmd,
    output vfs_pkg::vfs_status_t                    status,
    input  wire logic [vfs_pkg::CANVAS_W-1:0]       canvas_width,
    input  wire logic [vfs_pkg::CANVAS_W-1:0]       canvas_height,
    input  wire logic signed [vfs_pkg::COORD_W-1:0] x,
    input  wire logic signed [vfs_pkg::COORD_W-1:0] y,
    input  wire logic                               skip,
    output logic signed [vfs_pkg::COORD_W-1:0]      out_x,
    output logic signed [vfs_pkg::COORD_W-1:0]      out_y,
    output logic                                    below_min,
    output logic                                    degenerate
);
    import vfs_pkg::*;

    localparam int SH = COORD_FRAC_BITS + SCALE_FRAC_BITS;
    localparam int DW = CANVAS_W + SH;
    localparam int PW = 2 * SCALE_W;
    localparam int MW = PW - SCALE_FRAC_BITS;
    localparam int SW = MW + 2;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-31){1'b1}}, {31{1'b0}}};

    logic signed [COORD_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic                      box_started_reg;
    logic                      scale_ready_reg;
    logic [SCALE_W-1:0]        scale_reg;
    logic [COORD_W-1:0]        offset_x_reg, offset_y_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic                      skip_reg;
    logic [COORD_W-1:0]        magx_reg, magy_reg;
    logic                      negx_reg, negy_reg;
    logic [COORD_W-1:0]        ex_reg, ey_reg;
    logic [SCALE_W-1:0]        rx_reg, ry_reg;
    logic [PW-1:0]             prod_reg;
    logic [COORD_W-1:0]        ox_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                      below_min_reg;
    logic                      degenerate_reg;

    logic                      neg_x, neg_y;
    logic [COORD_W-1:0]        mag_x, mag_y;
    logic                      div_start;
    logic [DW-1:0]             div_dividend;
    logic [SCALE_W-1:0]        div_divisor;
    logic                      div_done;
    logic [SCALE_W-1:0]        div_quot;
    logic                      ex_zero, ey_zero;
    logic [SCALE_W-1:0]        s_sel;
    logic [SCALE_W-1:0]        mul_a;
    logic [COORD_W-1:0]        mul_b;
    logic [PW-1:0]             mul_p;
    logic [MW-1:0]             prod_hi;
    logic                      prod_frac;
    logic [COORD_W-1:0]        wq, hq;
    logic [MW-1:0]             wq_ext;
    logic [MW-1:0]             wdiff;
    logic [COORD_W-1:0]        cx;
    logic [MW:0]               hsum;
    logic [MW-1:0]             cy;
    logic [COORD_W-1:0]        cy_sat;
    logic [COORD_W-1:0]        oy;

    // off + (inv ? ~a : a) + cin, clamped to the signed 32-bit range
    function automatic logic [COORD_W-1:0] sat_sum(
        input logic [COORD_W-1:0] off,
        input logic [MW-1:0]      a,
        input logic               inv,
        input logic               cin
    );
        logic signed [SW-1:0] ae;
        logic signed [SW-1:0] sum;
        logic [COORD_W-1:0]   res;
        ae = SW'(a);
        if (inv)
        begin
            ae = ~ae;
        end
        sum = SW'($signed(off)) + ae + SW'(cin);
        if (sum > SAT_HI)
        begin
            res = 32'h7FFF_FFFF;
        end
        else if (sum < SAT_LO)
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = sum[COORD_W-1:0];
        end
        return res;
    endfunction

    // distance from the box minimum, sign and magnitude
    assign neg_x = x < min_x_reg;
    assign neg_y = y < min_y_reg;
    assign mag_x = neg_x ? COORD_W'(min_x_reg - x) : COORD_W'(x - min_x_reg);
    assign mag_y = neg_y ? COORD_W'(min_y_reg - y) : COORD_W'(y - min_y_reg);

    assign div_start = cmd.div_start_x | cmd.div_start_y;
    assign div_dividend = cmd.div_start_y ? {canvas_height, {SH{1'b0}}}
                                          : {canvas_width, {SH{1'b0}}};
    assign div_divisor = cmd.div_start_y ? ey_reg : ex_reg;

    vfs_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign ex_zero = ex_reg == '0;
    assign ey_zero = ey_reg == '0;

    always_comb
    begin
        if (!ex_zero && !ey_zero)
        begin
            s_sel = (rx_reg < ry_reg) ? rx_reg : ry_reg;
        end
        else if (!ex_zero)
        begin
            s_sel = rx_reg;
        end
        else if (!ey_zero)
        begin
            s_sel = ry_reg;
        end
        else
        begin
            s_sel = '0;
        end
    end

    // one shared 32x32 multiplier
    always_comb
    begin
        mul_a = cmd.mul_sx ? s_sel : scale_reg;
        if (cmd.mul_sx)
        begin
            mul_b = ex_reg;
        end
        else if (cmd.mul_sy)
        begin
            mul_b = ey_reg;
        end
        else if (cmd.map_x)
        begin
            mul_b = magx_reg;
        end
        else
        begin
            mul_b = magy_reg;
        end
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);
    assign prod_hi = prod_reg[PW-1:SCALE_FRAC_BITS];
    assign prod_frac = |prod_reg[SCALE_FRAC_BITS-1:0];

    // centering offsets
    assign wq = COORD_W'(canvas_width) << COORD_FRAC_BITS;
    assign hq = COORD_W'(canvas_height) << COORD_FRAC_BITS;
    assign wq_ext = MW'(wq);
    assign wdiff = wq_ext - prod_hi;
    assign cx = (prod_hi > wq_ext) ? '0 : {1'b0, wdiff[COORD_W-1:1]};
    assign hsum = (MW + 1)'(hq) + (MW + 1)'(prod_hi);
    assign cy = hsum[MW:1];
    assign cy_sat = (cy[MW-1:COORD_W-1] != '0) ? 32'h7FFF_FFFF : cy[COORD_W-1:0];

    // y axis flipped: offset_y - floor(scale * dy)
    assign oy = sat_sum(offset_y_reg, prod_hi, !negy_reg, negy_reg ? prod_frac : 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
            box_started_reg <= 1'b0;
            scale_ready_reg <= 1'b0;
        end
        else
        begin
            if (cmd.measure && !skip)
            begin
                // a measure after a transform opens a new point set
                if (!box_started_reg || scale_ready_reg)
                begin
                    min_x_reg <= x;
                    max_x_reg <= x;
                    min_y_reg <= y;
                    max_y_reg <= y;
                end
                else
                begin
                    if (x < min_x_reg)
                    begin
                        min_x_reg <= x;
                    end
                    if (x > max_x_reg)
                    begin
                        max_x_reg <= x;
                    end
                    if (y < min_y_reg)
                    begin
                        min_y_reg <= y;
                    end
                    if (y > max_y_reg)
                    begin
                        max_y_reg <= y;
                    end
                end
                box_started_reg <= 1'b1;
                scale_ready_reg <= 1'b0;
            end
            else if (cmd.off_y)
            begin
                scale_ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg <= x;
            y_reg <= y;
            skip_reg <= skip;
            negx_reg <= neg_x;
            negy_reg <= neg_y;
            magx_reg <= mag_x;
            magy_reg <= mag_y;
            ex_reg <= COORD_W'(max_x_reg - min_x_reg);
            ey_reg <= COORD_W'(max_y_reg - min_y_reg);
        end
        if (cmd.take_rx)
        begin
            rx_reg <= div_quot;
        end
        if (cmd.take_ry)
        begin
            ry_reg <= div_quot;
        end
        if (cmd.mul_sx)
        begin
            scale_reg <= s_sel;
        end
        if (cmd.mul_sx || cmd.mul_sy || cmd.map_x || cmd.map_y)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_sy)
        begin
            offset_x_reg <= cx;
        end
        if (cmd.off_y)
        begin
            offset_y_reg <= cy_sat;
        end
        if (cmd.map_y)
        begin
            ox_reg <= sat_sum(offset_x_reg, prod_hi, negx_reg, negx_reg & !prod_frac);
        end
        if (cmd.out_load)
        begin
            if (skip_reg)
            begin
                out_x_reg <= x_reg;
                out_y_reg <= y_reg;
                below_min_reg <= 1'b0;
            end
            else
            begin
                out_x_reg <= $signed(ox_reg);
                out_y_reg <= $signed(oy);
                below_min_reg <= negx_reg;
            end
            degenerate_reg <= (max_x_reg == min_x_reg) && (max_y_reg == min_y_reg);
        end
    end

    assign status.scale_ready = scale_ready_reg;
    assign status.div_done = div_done;
    assign out_x = out_x_reg;
    assign out_y = out_y_reg;
    assign below_min = below_min_reg;
    assign degenerate = degenerate_reg;

endmodule

`default_nettype wire

// File: rtl/viewport_fit_scaler.sv
`timescale 1ns / 1ps
`default_nettype none

// Fits a point set into a canvas with one uniform scale, centered, y axis flipped.
// Send the set with mode 0 to measure its bounding box (skipped points are
// ignored), then again with mode 1 to get one mapped point per item, Q24.8 in
// and out, saturated. A measure item is taken without leaving the idle state;
// a transform item runs accept, the shared 32x32 multiplier used twice, then
// the output register, and holds there while the previous result is still
// unread; no new item is taken before it is done. The first transform after
// a measure pass also fits the scale: two restoring divisions of
// 16+COORD_FRAC_BITS+SCALE_FRAC_BITS steps each on one shared divider, each
// with a start state and a wait for done, then steps for the scale, the x
// offset and the y offset. A new item is taken while a result waits in the
// output register. Canvas registers sit at byte address 0 (width) and 4
// (height) and are used at the next scale fit.
module viewport_fit_scaler #(
    parameter int COORD_FRAC_BITS = vfs_pkg::COORD_FRAC_BITS_DEF,
    parameter int SCALE_FRAC_BITS = vfs_pkg::SCALE_FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    vfs_in_if.sink                                  points,
    vfs_out_if.source                               results,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [vfs_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [vfs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [vfs_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready
);
    import vfs_pkg::*;

    logic [CANVAS_W-1:0] canvas_width_reg;
    logic [CANVAS_W-1:0] canvas_height_reg;
    logic                reg_idx;
    logic                wr_en;
    vfs_cmd_t            cmd;
    vfs_status_t         status;

    assign pready = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg <= CANVAS_WIDTH_RST;
            canvas_height_reg <= CANVAS_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CANVAS_WIDTH:  canvas_width_reg <= pwdata[CANVAS_W-1:0];
                REG_CANVAS_HEIGHT: canvas_height_reg <= pwdata[CANVAS_W-1:0];
                default:           canvas_width_reg <= canvas_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CANVAS_WIDTH:  prdata = APB_DATA_W'(canvas_width_reg);
            REG_CANVAS_HEIGHT: prdata = APB_DATA_W'(canvas_height_reg);
            default:           prdata = '0;
        endcase
    end

    vfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (points.valid),
        .in_mode   (points.mode),
        .in_ready  (points.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .status    (status)
    );

    vfs_dp #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .x             (points.x),
        .y             (points.y),
        .skip          (points.skip),
        .out_x         (results.out_x),
        .out_y         (results.out_y),
        .below_min     (results.below_min),
        .degenerate    (results.degenerate)
    );

endmodule

`default_nettype wire
